>>> design/b80_pkg.sv
// Shared types, constants and lookup functions for the base-80 text decoder.
// No dependencies; imported by b80_emit and base80_text_decoder.
package b80_pkg;

    localparam int CHAR_W          = 8;
    localparam int CODE_W          = 8;
    localparam int RADIX           = 80;
    localparam int DIGITS_PER_GROUP = 19;
    localparam int BYTES_PER_GROUP = 15;
    localparam int GROUP_W         = 121;
    localparam int BURST_W         = BYTES_PER_GROUP * 8;
    localparam int COUNT_W         = $clog2(DIGITS_PER_GROUP + 1);
    localparam int LEFT_W          = $clog2(BYTES_PER_GROUP + 1);

    localparam logic [CODE_W-1:0] CODE_ERROR = 8'hff;
    localparam logic [CODE_W-1:0] CODE_SPACE = 8'hfe;

    // Result kinds as carried on the result channel.
    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_END   = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    // Request from the group stage to the result serialiser.
    typedef struct packed {
        logic               load;
        logic [LEFT_W-1:0]  count;
        logic [BURST_W-1:0] value;
        kind_t              kind;
        logic               done;
    } burst_req_t;

    // Map one character to its digit value, or to the space or error code.
    function automatic logic [CODE_W-1:0] b80_char_code(input logic [CHAR_W-1:0] ch);
        logic [CODE_W-1:0] code;
        unique case (ch) inside
            8'h21:          code = 8'd0;
            8'h24:          code = 8'd1;
            8'h28:          code = 8'd2;
            8'h29:          code = 8'd3;
            8'h2b:          code = 8'd4;
            8'h2c:          code = 8'd5;
            8'h2d:          code = 8'd6;
            [8'h30:8'h39]:  code = ch - 8'd41;
            8'h3b:          code = 8'd17;
            8'h3d:          code = 8'd18;
            8'h40:          code = 8'd19;
            [8'h41:8'h5a]:  code = ch - 8'd45;
            8'h5b:          code = 8'd46;
            8'h5d:          code = 8'd47;
            8'h5e:          code = 8'd48;
            8'h5f:          code = 8'd49;
            8'h60:          code = 8'd50;
            [8'h61:8'h7a]:  code = ch - 8'd46;
            8'h7b:          code = 8'd77;
            8'h7d:          code = 8'd78;
            8'h7e:          code = 8'd79;
            8'h09, 8'h0a, 8'h0d, 8'h20: code = CODE_SPACE;
            default:        code = CODE_ERROR;
        endcase
        return code;
    endfunction

    // Number of bytes carried by a group of the given digit count.
    function automatic logic [LEFT_W-1:0] b80_bytes_for(input logic [COUNT_W-1:0] digits);
        logic [LEFT_W-1:0] n;
        unique case (digits)
            5'd0, 5'd1:   n = 4'd0;
            5'd2:         n = 4'd1;
            5'd3:         n = 4'd2;
            5'd4, 5'd5:   n = 4'd3;
            5'd6:         n = 4'd4;
            5'd7:         n = 4'd5;
            5'd8:         n = 4'd6;
            5'd9, 5'd10:  n = 4'd7;
            5'd11:        n = 4'd8;
            5'd12:        n = 4'd9;
            5'd13:        n = 4'd10;
            5'd14, 5'd15: n = 4'd11;
            5'd16:        n = 4'd12;
            5'd17:        n = 4'd13;
            5'd18:        n = 4'd14;
            5'd19:        n = 4'd15;
            default:      n = 4'd0;
        endcase
        return n;
    endfunction

endpackage

>>> design/b80_emit.sv
// Result serialiser: holds one burst of up to fifteen results and hands them
// out one transfer per cycle while m_tready is high. Depends on b80_pkg.
module b80_emit (
    input  logic                aclk,
    input  logic                aresetn,
    input  b80_pkg::burst_req_t req,
    output logic                busy,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,   // [7:0] data_byte
    output logic                m_tlast,   // run_last
    output logic [2:0]          m_tuser    // [1:0] kind, [2] stream_done
);
    import b80_pkg::*;

    logic                busy_reg, busy_next;
    logic [LEFT_W-1:0]   left_reg, left_next;
    logic [BURST_W-1:0]  value_reg, value_next;
    kind_t               kind_reg, kind_next;
    logic                done_reg, done_next;
    logic [LEFT_W-1:0]   byte_idx;
    logic                last_one;
    logic                can_load;

    // A new burst may load when idle or in the cycle of the last transfer.
    assign can_load = !busy_reg || (m_tready && last_one);

    // Load a new burst when free, count down on each accepted transfer.
    always_comb begin
        busy_next  = busy_reg;
        left_next  = left_reg;
        value_next = value_reg;
        kind_next  = kind_reg;
        done_next  = done_reg;
        if (req.load && can_load) begin
            busy_next  = 1'b1;
            left_next  = req.count;
            value_next = req.value;
            kind_next  = req.kind;
            done_next  = req.done;
        end else if (busy_reg && m_tready) begin
            if (last_one) begin
                busy_next = 1'b0;
            end else begin
                left_next = left_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            left_reg <= '0;
            kind_reg <= KIND_BYTE;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            left_reg <= left_next;
            kind_reg <= kind_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    // Bytes leave most significant first: the remaining count picks the byte.
    assign byte_idx = left_reg - 1'b1;
    assign last_one = (left_reg == LEFT_W'(1));

    assign busy     = !can_load;
    assign m_tvalid = busy_reg;
    assign m_tdata  = (kind_reg == KIND_BYTE) ? value_reg[byte_idx*8 +: 8] : 8'd0;
    assign m_tlast  = last_one;
    assign m_tuser  = {last_one && done_reg, kind_reg};

    // A marker or error result is always a run of one.
    a_single_marker: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && kind_reg != KIND_BYTE) |-> m_tlast)
        else $error("marker or error result is not the last of its run");

    // Without a new burst, the serialiser goes idle right after the last transfer of a run.
    a_idle_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast && !req.load) |=> !busy_reg)
        else $error("serialiser still busy after the last transfer");

    // A burst never holds more bytes than one group carries.
    a_burst_len: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (left_reg != '0 && left_reg <= LEFT_W'(BYTES_PER_GROUP)))
        else $error("burst length out of range");

endmodule

>>> design/base80_text_decoder.sv
// Base-80 text decoder: input register, group accumulator and result serialiser.
// A character passes the input register, then its first result loads the serialiser and is presented.
// Throughput: one character per cycle; a result-causing character waits while a burst drains.
// A burst of n results takes n accepted transfers; the next burst loads in the cycle of the last transfer.
// Reset (aresetn low, synchronous) empties the input register, the group and the serialiser.
module base80_text_decoder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] text_char
    input  logic       s_tlast,   // final_char
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] data_byte
    output logic       m_tlast,   // run_last
    output logic [2:0] m_tuser    // [1:0] kind, [2] stream_done
);
    import b80_pkg::*;

    logic                in_vld_reg;
    logic [CHAR_W-1:0]   in_char_reg;
    logic                in_fin_reg;
    logic [GROUP_W-1:0]  group_reg, group_next;
    logic [COUNT_W-1:0]  cnt_reg, cnt_next;

    logic [CODE_W-1:0]   code;
    logic                is_err, is_space, is_digit;
    logic [COUNT_W-1:0]  cnt_new;
    logic [GROUP_W-1:0]  grp_mul, grp_new;
    logic                full;
    logic                needs_out;
    logic                advance;
    logic [LEFT_W-1:0]   n_bytes;
    logic                emit_busy;
    burst_req_t          req;

    // Input register: one character waits here while it is decoded.
    assign s_tready = !in_vld_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_char_reg <= s_tdata;
            in_fin_reg  <= s_tlast;
        end
    end

    // Decode the character and fold a digit into the group: value*80 + digit.
    always_comb begin
        code     = b80_char_code(in_char_reg);
        is_err   = (code == CODE_ERROR);
        is_space = (code == CODE_SPACE);
        is_digit = !is_err && !is_space;
        grp_mul  = (group_reg << 6) + (group_reg << 4) + GROUP_W'(code);
        grp_new  = is_digit ? grp_mul : group_reg;
        cnt_new  = is_digit ? cnt_reg + 1'b1 : cnt_reg;
        full     = (cnt_new == COUNT_W'(DIGITS_PER_GROUP));
        needs_out = is_err || full || in_fin_reg;
        advance  = in_vld_reg && (!needs_out || !emit_busy);
        n_bytes  = full ? LEFT_W'(BYTES_PER_GROUP) : b80_bytes_for(cnt_new);
    end

    // Build the burst request for the serialiser.
    always_comb begin
        req.load  = in_vld_reg && needs_out && !emit_busy;
        req.value = grp_new[BURST_W-1:0];
        req.done  = is_err || in_fin_reg;
        if (is_err) begin
            req.kind  = KIND_ERROR;
            req.count = LEFT_W'(1);
        end else if (n_bytes == '0) begin
            req.kind  = KIND_END;
            req.count = LEFT_W'(1);
        end else begin
            req.kind  = KIND_BYTE;
            req.count = n_bytes;
        end
    end

    // Group state: cleared whenever a burst is issued, else takes the new value when a character advances.
    always_comb begin
        group_next = group_reg;
        cnt_next   = cnt_reg;
        if (advance) begin
            if (needs_out) begin
                group_next = '0;
                cnt_next   = '0;
            end else begin
                group_next = grp_new;
                cnt_next   = cnt_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            group_reg <= '0;
            cnt_reg   <= '0;
        end else begin
            group_reg <= group_next;
            cnt_reg   <= cnt_next;
        end
    end

    b80_emit u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (req),
        .busy     (emit_busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // A partial group never holds a full group's worth of digits.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg < COUNT_W'(DIGITS_PER_GROUP))
        else $error("digit count reached a full group without being cleared");

    // A burst is only requested when the serialiser is free.
    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        req.load |-> !emit_busy)
        else $error("burst requested while the serialiser is busy");

    // An issued burst always leaves the group empty.
    a_group_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        req.load |=> (cnt_reg == '0 && group_reg == '0))
        else $error("group not cleared after a burst");

endmodule
